// ===== hdl/alm_pkg.sv =====
// Shared types, codes and constants of the audio level meter.
package alm_pkg;

  typedef enum logic [1:0] {
    OP_LEVEL    = 2'd0,
    OP_TICK     = 2'd1,
    OP_PEAK_RST = 2'd2,
    OP_BYPASS   = 2'd3
  } op_t;

  localparam logic [1:0] REG_MIN_DB  = 2'd0;
  localparam logic [1:0] REG_MAX_DB  = 2'd1;
  localparam logic [1:0] REG_ATTACK  = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

  localparam logic signed [16:0] MIN_DB_RST  = -17'sd15360;
  localparam logic signed [12:0] MAX_DB_RST  = 13'sd1536;
  localparam logic [15:0]        ATTACK_RST  = 16'd19661;
  localparam logic [15:0]        RELEASE_RST = 16'd58982;

  localparam logic [16:0]        FULL_SCALE  = 17'd65536;
  localparam logic [16:0]        SMALL_LEVEL = 17'd66;
  localparam logic signed [16:0] ZERO_DB_Q88 = -17'sd25600;

  // 20*log10(2) in Q16, consumed LSB first by the serial multiplier
  localparam int          DB_K_BITS   = 19;
  localparam logic [18:0] DB_PER_LOG2 = 19'd394566;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_NORM,
    CV_LOOK,
    CV_MUL,
    CV_DONE
  } conv_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIV,
    ST_TICK,
    ST_COMMIT,
    ST_DONE
  } mtr_state_t;

  typedef struct packed {
    logic        start;
    logic [23:0] magnitude;
  } conv_req_t;

  typedef struct packed {
    logic               done;
    logic signed [16:0] db;
  } conv_rsp_t;

  // log2(1 + idx/2^bits) in Q0.16, built bit by bit through repeated squaring
  function automatic logic [15:0] log_frac_entry(input int unsigned idx,
                                                 input int unsigned bits);
    longint unsigned x;
    logic [15:0]     f;
    x = ((longint'(1) << bits) + longint'(idx)) << (30 - bits);
    f = '0;
    for (int b = 15; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (longint'(1) << 31)) begin
        x    = x >> 1;
        f[b] = 1'b1;
      end
    end
    return f;
  endfunction

endpackage

// ===== hdl/alm_db_conv.sv =====
// Linear magnitude to Q8.8 dB: serial normalize, table log2, serial constant multiply.
module alm_db_conv #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alm_pkg::conv_req_t  req,
  output alm_pkg::conv_rsp_t  rsp
);

  localparam int TAB_N = 1 << LOG_TABLE_BITS;
  localparam int ACC_W = 42;

  alm_pkg::conv_state_t state_r, state_nxt;

  logic [23:0]              mag_r, mag_nxt;
  logic [4:0]               exp_r, exp_nxt;
  logic signed [ACC_W-1:0]  mcand_r, mcand_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [alm_pkg::DB_K_BITS-1:0] mult_r, mult_nxt;
  logic signed [16:0]       db_r, db_nxt;

  logic [15:0]        log_tab [TAB_N];
  logic [5:0]         e_off;
  logic signed [21:0] log_val;

  for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
    localparam logic [15:0] ENTRY = alm_pkg::log_frac_entry(gi, LOG_TABLE_BITS);
    assign log_tab[gi] = ENTRY;
  end

  // integer part of log2 is exponent - 23, fraction from the table
  assign e_off   = {1'b0, exp_r} - 6'd23;
  assign log_val = {e_off, log_tab[mag_r[22 -: LOG_TABLE_BITS]]};
  assign acc_sum = acc_r + (mult_r[0] ? mcand_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alm_pkg::CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r   <= mag_nxt;
    exp_r   <= exp_nxt;
    mcand_r <= mcand_nxt;
    acc_r   <= acc_nxt;
    mult_r  <= mult_nxt;
    db_r    <= db_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    exp_nxt   = exp_r;
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    mult_nxt  = mult_r;
    db_nxt    = db_r;
    case (state_r)
      alm_pkg::CV_IDLE: begin
        if (req.start) begin
          if (req.magnitude == '0) begin
            db_nxt    = alm_pkg::ZERO_DB_Q88;
            state_nxt = alm_pkg::CV_DONE;
          end else begin
            mag_nxt   = req.magnitude;
            exp_nxt   = 5'd23;
            state_nxt = alm_pkg::CV_NORM;
          end
        end
      end
      alm_pkg::CV_NORM: begin
        if (mag_r[23]) begin
          state_nxt = alm_pkg::CV_LOOK;
        end else begin
          mag_nxt = {mag_r[22:0], 1'b0};
          exp_nxt = exp_r - 5'd1;
        end
      end
      alm_pkg::CV_LOOK: begin
        mcand_nxt = ACC_W'(log_val);
        acc_nxt   = ACC_W'(24'h80_0000);  // round to nearest, ties up
        mult_nxt  = alm_pkg::DB_PER_LOG2;
        state_nxt = alm_pkg::CV_MUL;
      end
      alm_pkg::CV_MUL: begin
        acc_nxt   = acc_sum;
        mcand_nxt = mcand_r <<< 1;
        mult_nxt  = mult_r >> 1;
        if (mult_r[alm_pkg::DB_K_BITS-1:1] == '0) begin
          db_nxt    = acc_sum[40:24];
          state_nxt = alm_pkg::CV_DONE;
        end
      end
      alm_pkg::CV_DONE: begin
        state_nxt = alm_pkg::CV_IDLE;
      end
      default: begin
        state_nxt = alm_pkg::CV_IDLE;
      end
    endcase
  end

  assign rsp.done = (state_r == alm_pkg::CV_DONE);
  assign rsp.db   = db_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done)
    else $error("conversion done held longer than one cycle");

  a_norm_leads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alm_pkg::CV_LOOK) |-> mag_r[23])
    else $error("table lookup without a normalized magnitude");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && state_r == alm_pkg::CV_IDLE && req.magnitude != '0)
      |=> state_r == alm_pkg::CV_NORM)
    else $error("nonzero magnitude did not enter normalization");

endmodule

// ===== hdl/audio_level_meter_peak_hold.sv =====
// Audio level meter with peak hold: control, divider, smoother and state.
// Sequence, accepting edge to out_valid: level runs normalize, lookup, multiply,
//   divide (skipped when clamped) and handoff; tick runs a shift-add; peak reset and bypass go to ST_DONE.
// Throughput: one transaction at a time; the next is taken once the previous
//   result sits in the output register.
// Reset: rst_n synchronous active low; levels and bypass clear, peak dB and range to defaults.
module audio_level_meter_peak_hold #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,

  // input transaction channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [23:0]        in_magnitude,
  input  logic               in_bypass_flag,

  // result transaction channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        out_shown_level,
  output logic [16:0]        out_peak_level,
  output logic signed [16:0] out_peak_db,
  output logic               out_bypass_state,

  // configuration writes
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam int TACC_W = 35;

  // configuration registers
  logic signed [16:0] min_db_r;
  logic signed [12:0] max_db_r;
  logic [15:0]        attack_r;
  logic [15:0]        release_r;
  logic signed [16:0] max_ext;

  // meter state
  logic [16:0]        target_r, target_nxt;
  logic [16:0]        smooth_r, smooth_nxt;
  logic [16:0]        peak_r, peak_nxt;
  logic signed [16:0] peak_db_r, peak_db_nxt;
  logic               bypass_r, bypass_nxt;

  // sequencer and datapath
  alm_pkg::mtr_state_t state_r, state_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic signed [16:0]  db_r, db_nxt;
  logic [16:0]         lvl_r, lvl_nxt;      // quotient shift register / new target
  logic [15:0]         rem_r, rem_nxt;
  logic [15:0]         den_r, den_nxt;
  logic [15:0]         coef_r, coef_nxt;
  logic signed [TACC_W-1:0] dsh_r, dsh_nxt;
  logic signed [TACC_W-1:0] tacc_r, tacc_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [16:0]        out_shown_r;
  logic [16:0]        out_peak_r;
  logic signed [16:0] out_peak_db_r;
  logic               out_bypass_r;
  logic               out_load;

  alm_pkg::conv_req_t conv_req;
  alm_pkg::conv_rsp_t conv_rsp;

  // combinational helpers
  logic               in_accept;
  logic [16:0]        rem2;
  logic               rem_ge;
  logic signed [17:0] num_diff;
  logic signed [17:0] den_diff;
  logic signed [17:0] lvl_diff;
  logic signed [TACC_W-1:0] tacc_sum;
  logic [17:0]        sm_raw;

  assign max_ext   = 17'(max_db_r);
  assign in_ready  = (state_r == alm_pkg::ST_IDLE);
  assign in_accept = in_valid && in_ready;

  assign rem2     = {rem_r, 1'b0};
  assign rem_ge   = rem2 >= {1'b0, den_r};
  assign num_diff = 18'(conv_rsp.db) - 18'(min_db_r);
  assign den_diff = 18'(max_ext) - 18'(min_db_r);
  assign lvl_diff = $signed({1'b0, smooth_r}) - $signed({1'b0, target_r});
  assign tacc_sum = tacc_r + (coef_r[0] ? dsh_r : '0);
  assign sm_raw   = tacc_sum[33:16];

  assign conv_req.start     = in_accept && (alm_pkg::op_t'(in_operation) == alm_pkg::OP_LEVEL);
  assign conv_req.magnitude = in_magnitude;

  alm_db_conv #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_db_conv (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (conv_req),
    .rsp  (conv_rsp)
  );

  // configuration port: plain write, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_db_r  <= alm_pkg::MIN_DB_RST;
      max_db_r  <= alm_pkg::MAX_DB_RST;
      attack_r  <= alm_pkg::ATTACK_RST;
      release_r <= alm_pkg::RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        alm_pkg::REG_MIN_DB:  min_db_r  <= cfg_data;
        alm_pkg::REG_MAX_DB:  max_db_r  <= cfg_data[12:0];
        alm_pkg::REG_ATTACK:  attack_r  <= cfg_data[15:0];
        alm_pkg::REG_RELEASE: release_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      target_r    <= '0;
      smooth_r    <= '0;
      peak_r      <= '0;
      peak_db_r   <= alm_pkg::MIN_DB_RST;
      bypass_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      target_r    <= target_nxt;
      smooth_r    <= smooth_nxt;
      peak_r      <= peak_nxt;
      peak_db_r   <= peak_db_nxt;
      bypass_r    <= bypass_nxt;
    end
    cnt_r  <= cnt_nxt;
    db_r   <= db_nxt;
    lvl_r  <= lvl_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    coef_r <= coef_nxt;
    dsh_r  <= dsh_nxt;
    tacc_r <= tacc_nxt;
    if (out_load) begin
      out_shown_r   <= smooth_r;
      out_peak_r    <= peak_r;
      out_peak_db_r <= peak_db_r;
      out_bypass_r  <= bypass_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    db_nxt        = db_r;
    lvl_nxt       = lvl_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    coef_nxt      = coef_r;
    dsh_nxt       = dsh_r;
    tacc_nxt      = tacc_r;
    target_nxt    = target_r;
    smooth_nxt    = smooth_r;
    peak_nxt      = peak_r;
    peak_db_nxt   = peak_db_r;
    bypass_nxt    = bypass_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      alm_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (alm_pkg::op_t'(in_operation))
            alm_pkg::OP_LEVEL: begin
              state_nxt = alm_pkg::ST_CONV;
            end
            alm_pkg::OP_TICK: begin
              // new = target*2^16 + (old - target)*c + half LSB
              coef_nxt  = (target_r > smooth_r) ? attack_r : release_r;
              dsh_nxt   = TACC_W'(lvl_diff);
              tacc_nxt  = TACC_W'({target_r, 16'h8000});
              cnt_nxt   = '0;
              state_nxt = alm_pkg::ST_TICK;
            end
            alm_pkg::OP_PEAK_RST: begin
              peak_nxt    = '0;
              peak_db_nxt = min_db_r;
              state_nxt   = alm_pkg::ST_DONE;
            end
            alm_pkg::OP_BYPASS: begin
              bypass_nxt = in_bypass_flag;
              if (in_bypass_flag) begin
                target_nxt = '0;
              end
              state_nxt = alm_pkg::ST_DONE;
            end
            default: ;
          endcase
        end
      end
      alm_pkg::ST_CONV: begin
        if (conv_rsp.done) begin
          db_nxt = conv_rsp.db;
          // below-range test first, so an empty range never reaches the divider
          if (conv_rsp.db <= min_db_r) begin
            lvl_nxt   = '0;
            state_nxt = alm_pkg::ST_COMMIT;
          end else if (conv_rsp.db >= max_ext) begin
            lvl_nxt   = alm_pkg::FULL_SCALE;
            state_nxt = alm_pkg::ST_COMMIT;
          end else begin
            rem_nxt   = num_diff[15:0];
            den_nxt   = den_diff[15:0];
            lvl_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = alm_pkg::ST_DIV;
          end
        end
      end
      alm_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_nxt = rem_ge ? 16'(rem2 - {1'b0, den_r}) : rem2[15:0];
        lvl_nxt = {lvl_r[15:0], rem_ge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = alm_pkg::ST_COMMIT;
        end
      end
      alm_pkg::ST_TICK: begin
        // shift-add over coefficient bits, LSB first
        tacc_nxt = tacc_sum;
        dsh_nxt  = dsh_r <<< 1;
        coef_nxt = coef_r >> 1;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          if (sm_raw > 18'(alm_pkg::FULL_SCALE)) begin
            smooth_nxt = alm_pkg::FULL_SCALE;
          end else if (sm_raw < 18'(alm_pkg::SMALL_LEVEL)) begin
            smooth_nxt = '0;
          end else begin
            smooth_nxt = sm_raw[16:0];
          end
          state_nxt = alm_pkg::ST_DONE;
        end
      end
      alm_pkg::ST_COMMIT: begin
        target_nxt = lvl_r;
        if (lvl_r > peak_r) begin
          peak_nxt    = lvl_r;
          peak_db_nxt = db_r;
        end
        state_nxt = alm_pkg::ST_DONE;
      end
      alm_pkg::ST_DONE: begin
        // hold here until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = alm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = alm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_shown_level  = out_shown_r;
  assign out_peak_level   = out_peak_r;
  assign out_peak_db      = out_peak_db_r;
  assign out_bypass_state = out_bypass_r;

  a_peak_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_operation == alm_pkg::OP_PEAK_RST)
      |=> (peak_r == '0) && (peak_db_r == $past(min_db_r)))
    else $error("peak reset did not clear the held peak");

  a_bypass_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_operation == alm_pkg::OP_BYPASS && in_bypass_flag)
      |=> bypass_r && (target_r == '0))
    else $error("bypass set did not zero the target");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (peak_r <= alm_pkg::FULL_SCALE) && (target_r <= alm_pkg::FULL_SCALE) &&
    ((smooth_r == '0) || (smooth_r >= alm_pkg::SMALL_LEVEL)))
    else $error("level state out of range");

  a_conv_owned: assert property (@(posedge clk) disable iff (!rst_n)
    conv_rsp.done |-> (state_r == alm_pkg::ST_CONV))
    else $error("dB result arrived outside a level transaction");

endmodule
